FILE: sv/slrg_pkg.sv
// Shared types and constants of the shuffled Lehmer random generator.
// No dependencies; imported by slrg_lcg_unit and the top level.
package slrg_pkg;

    localparam int VALUE_W      = 31;
    localparam int MUL_W        = 17;
    localparam int PROD_W       = VALUE_W + MUL_W;
    localparam int WARMUP_STEPS = 8;

    typedef logic [VALUE_W-1:0] value_t;

    localparam value_t           LCG_MOD = 31'h7fffffff;
    localparam logic [MUL_W-1:0] LCG_MUL = 17'h10ff5;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_WRITE = 6'b100000
    } seq_state_t;

endpackage

FILE: sv/slrg_lcg_unit.sv
// Shared generator step: registered product seed * 69621, then Mersenne fold mod 2^31-1.
// Depends on slrg_pkg.
module slrg_lcg_unit
    import slrg_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  value_t seed,
    output value_t next_seed
);

    logic [PROD_W-1:0] prod_reg;
    logic [VALUE_W:0]  fold_sum;
    logic [VALUE_W:0]  fold_red;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(seed) * PROD_W'(LCG_MUL);
        end
    end

    always_comb
    begin
        fold_sum = {1'b0, prod_reg[VALUE_W-1:0]} + (VALUE_W + 1)'(prod_reg[PROD_W-1:VALUE_W]);
        if (fold_sum >= {1'b0, LCG_MOD})
        begin
            fold_red = fold_sum - {1'b0, LCG_MOD};
        end
        else
        begin
            fold_red = fold_sum;
        end
    end

    assign next_seed = fold_red[VALUE_W-1:0];

endmodule

FILE: sv/shuffled_lehmer_random_generator_unit.sv
// Top level of the shuffled Lehmer random generator: sequencer, shuffle memory, output register.
// Depends on slrg_pkg and slrg_lcg_unit.
//
// A draw beat runs from acceptance through one state that picks the
// table entry by a constant reciprocal multiply of the last output, one multiply and one fold
// state in the shared generator unit, a registered memory read and the table write-back. The
// write-back waits while the output register still holds an untaken result. A reseed beat
// runs TABLE_DEPTH + 8 generator steps, each passing the shared unit's multiply and fold
// states. A reseed returns no result; the input side is stalled while a beat is in
// work, and a finished draw waits in the output register while the next beat is accepted.
module shuffled_lehmer_random_generator_unit
    import slrg_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   operation,
    input  value_t seed_value,
    output logic   out_valid,
    input  logic   out_stall,
    output value_t random_value
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + WARMUP_STEPS);
    localparam longint unsigned PICK_DIV = 64'd1 + 64'd2147483646 / 64'(TABLE_DEPTH);
    localparam int PICK_SH = VALUE_W + $clog2(PICK_DIV);
    localparam longint unsigned PICK_RCP = ((64'd1 << PICK_SH) + PICK_DIV - 64'd1) / PICK_DIV;
    localparam int PW = 2 * VALUE_W + 1;

    seq_state_t     state_reg, state_next;
    logic           op_reg, op_next;
    logic           seeded_reg, seeded_next;
    logic           out_valid_reg, out_valid_next;
    logic [CW-1:0]  count_reg, count_next;
    value_t         seed_reg, seed_next;
    value_t         last_reg, last_next;
    logic [AW-1:0]  quot_reg, quot_next;
    value_t         result_reg, result_next;

    value_t         shuffle_mem [TABLE_DEPTH];
    value_t         rdata_reg;
    value_t         rdata;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    value_t         mem_wdata;
    logic [AW-1:0]  pick_idx;
    logic [PW-1:0]  pick_prod;
    logic [AW-1:0]  pick_quot;
    logic           lcg_load;
    value_t         lcg_result;
    logic           out_take;

    slrg_lcg_unit u_lcg
    (
        .clk       (clk),
        .load      (lcg_load),
        .seed      (seed_reg),
        .next_seed (lcg_result)
    );

    assign lcg_load     = (state_reg == ST_MUL);
    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign random_value = result_reg;
    assign out_take     = out_valid_reg && !out_stall;
    assign rdata        = seeded_reg ? rdata_reg : '0;

    assign pick_prod = PW'(last_reg) * PW'(PICK_RCP);
    assign pick_quot = pick_prod[PICK_SH +: AW];

    always_comb
    begin
        if ({1'b0, quot_reg} >= (AW + 1)'(TABLE_DEPTH))
        begin
            pick_idx = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            pick_idx = quot_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        seed_next      = seed_reg;
        last_next      = last_reg;
        quot_next      = quot_reg;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = pick_idx;
        mem_wdata      = seed_reg;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = operation;
                    if (operation)
                    begin
                        seed_next  = seed_value;
                        count_next = CW'(TABLE_DEPTH + WARMUP_STEPS - 1);
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                quot_next  = pick_quot;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                seed_next = lcg_result;
                if (op_reg)
                begin
                    if (count_reg < CW'(TABLE_DEPTH))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = count_reg[AW-1:0];
                        mem_wdata = lcg_result;
                    end
                    if (count_reg == '0)
                    begin
                        last_next   = lcg_result;
                        seeded_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    mem_we         = 1'b1;
                    last_next      = rdata;
                    result_next    = rdata;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= 1'b0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            seed_reg      <= '0;
            last_reg      <= '0;
            quot_reg      <= '0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            seed_reg      <= seed_next;
            last_reg      <= last_next;
            quot_reg      <= quot_next;
            result_reg    <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shuffle_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            rdata_reg <= shuffle_mem[pick_idx];
        end
    end

    a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared outside the write-back step");

    a_reseed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD && op_reg && count_reg == '0) |=>
            (seeded_reg && state_reg == ST_IDLE))
        else $error("reseed did not finish after the last fill step");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ({1'b0, quot_reg} < (AW + 1)'(TABLE_DEPTH)))
        else $error("picked table entry beyond the table depth");

    a_last_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg != LCG_MOD))
        else $error("last output reached the modulus");

    a_draw_holds_table: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !op_reg) |-> (state_reg == ST_WRITE && mem_waddr == pick_idx))
        else $error("draw wrote the table outside the write-back step");

endmodule
